// ----- rtl/core/hsv_to_rgb_converter_top_defines.svh -----
// ----------------------------------------------------------------------------
// hsv to rgb converter assertion macros
// concurrent assertion wrappers shared by the converter rtl
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// checked property, disabled while reset is low
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, live during reset too
`define HSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv to rgb converter package
// fixed-point constants and sector codes of the converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_R_Y = 3'd0;
    localparam t_sector SEC_Y_G = 3'd1;
    localparam t_sector SEC_G_C = 3'd2;
    localparam t_sector SEC_C_B = 3'd3;
    localparam t_sector SEC_B_M = 3'd4;
    localparam t_sector SEC_M_R = 3'd5;

    localparam logic [12:0] HUE_FULL     = 13'd5760;
    localparam logic [9:0]  SECTOR_SPAN  = 10'd960;
    localparam logic [7:0]  FRAC_ONE     = 8'd255;
    localparam logic [17:0] SECTOR_SCALE = 18'd244800;

    // sector scale = 64 * scale_div
    localparam int          SCALE_SHIFT  = 6;
    localparam logic [11:0] SCALE_DIV    = 12'd3825;

    localparam longint      P_RECIP_L    = (longint'(1) << 24) / 255;
    localparam logic [16:0] P_RECIP      = 17'(P_RECIP_L);
    localparam longint      Q_RECIP_L    = (longint'(1) << 32) / 3825;
    localparam logic [20:0] Q_RECIP      = 21'(Q_RECIP_L);

endpackage

// ----- rtl/core/hsv_to_rgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// hsv to rgb converter
// structure: 8 register stages from input transaction to output valid
// throughput: one transaction per cycle while the output accepts; each stage has its own valid and
// advances whenever the stage after it is empty or moving
// reset: synchronous active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv_to_rgb_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[12:0], saturation[20:13], brightness[28:21]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsv2rgb_pkg::*;

    localparam int Stages = 8;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] stage_en;

    // stage 1
    logic [12:0] r1_hue;
    logic [7:0]  r1_sat, r1_val;
    // stage 2
    t_sector     r2_sec;
    logic [9:0]  r2_rem;
    logic [7:0]  r2_sat, r2_val;
    // stage 3
    t_sector     r3_sec;
    logic [17:0] r3_a, r3_b;
    logic [15:0] r3_pm;
    logic [7:0]  r3_val;
    // stage 4
    t_sector     r4_sec;
    logic [17:0] r4_nq, r4_nt;
    logic [15:0] r4_pm;
    logic [7:0]  r4_pa, r4_val;
    // stage 5
    t_sector     r5_sec;
    logic [25:0] r5_mq, r5_mt;
    logic [7:0]  r5_p, r5_val;
    // stage 6
    t_sector     r6_sec;
    logic [19:0] r6_yq, r6_yt;
    logic [7:0]  r6_qq, r6_qt, r6_p, r6_val;
    // stage 7
    t_sector     r7_sec;
    logic [7:0]  r7_q, r7_t, r7_p, r7_val;
    // stage 8
    logic [7:0]  r_red, r_green, r_blue;

    logic [12:0] n1_hue;
    t_sector     n2_sec;
    logic [12:0] n2_base, n2_diff;
    logic [9:0]  n3_inv;
    logic [32:0] n4_pprod;
    logic [15:0] n5_pback, n5_pres;
    logic [7:0]  n5_p;
    logic [19:0] n6_yq, n6_yt;
    logic [40:0] n6_qprod, n6_tprod;
    logic [19:0] n7_qres, n7_tres;
    logic [7:0]  n7_q, n7_t;
    logic [7:0]  n_red, n_green, n_blue;

    always_comb begin
        stage_en[Stages-1] = !r_vld[Stages-1] || m_axis_tready;
        for (int k = Stages - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = r_vld[Stages-1];
    assign m_axis_tdata  = {r_blue, r_green, r_red};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < Stages; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= (k == 0) ? s_axis_tvalid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // hue wrap
    always_comb begin
        if (s_axis_tdata[12:0] >= HUE_FULL) begin
            n1_hue = s_axis_tdata[12:0] - HUE_FULL;
        end else begin
            n1_hue = s_axis_tdata[12:0];
        end
    end

    // sector split
    always_comb begin
        if (r1_hue >= 13'(SECTOR_SPAN) * 13'd5) begin
            n2_sec  = SEC_M_R;
            n2_base = 13'(SECTOR_SPAN) * 13'd5;
        end else if (r1_hue >= 13'(SECTOR_SPAN) * 13'd4) begin
            n2_sec  = SEC_B_M;
            n2_base = 13'(SECTOR_SPAN) * 13'd4;
        end else if (r1_hue >= 13'(SECTOR_SPAN) * 13'd3) begin
            n2_sec  = SEC_C_B;
            n2_base = 13'(SECTOR_SPAN) * 13'd3;
        end else if (r1_hue >= 13'(SECTOR_SPAN) * 13'd2) begin
            n2_sec  = SEC_G_C;
            n2_base = 13'(SECTOR_SPAN) * 13'd2;
        end else if (r1_hue >= 13'(SECTOR_SPAN)) begin
            n2_sec  = SEC_Y_G;
            n2_base = 13'(SECTOR_SPAN);
        end else begin
            n2_sec  = SEC_R_Y;
            n2_base = 13'd0;
        end
        n2_diff = r1_hue - n2_base;
    end

    assign n3_inv   = SECTOR_SPAN - r2_rem;
    assign n4_pprod = 33'(r3_pm) * 33'(P_RECIP);

    // p = pm / 255, reciprocal estimate plus one correction
    assign n5_pback = 16'(r4_pa) * 16'(FRAC_ONE);
    assign n5_pres  = r4_pm - n5_pback;
    assign n5_p     = (n5_pres >= 16'(FRAC_ONE)) ? r4_pa + 8'd1 : r4_pa;

    // q, t = m / 244800 = (m >> 6) / 3825
    assign n6_yq    = r5_mq[25:SCALE_SHIFT];
    assign n6_yt    = r5_mt[25:SCALE_SHIFT];
    assign n6_qprod = 41'(n6_yq) * 41'(Q_RECIP);
    assign n6_tprod = 41'(n6_yt) * 41'(Q_RECIP);

    assign n7_qres  = r6_yq - 20'(r6_qq) * 20'(SCALE_DIV);
    assign n7_tres  = r6_yt - 20'(r6_qt) * 20'(SCALE_DIV);
    assign n7_q     = (n7_qres >= 20'(SCALE_DIV)) ? r6_qq + 8'd1 : r6_qq;
    assign n7_t     = (n7_tres >= 20'(SCALE_DIV)) ? r6_qt + 8'd1 : r6_qt;

    always_comb begin
        case (r7_sec)
            SEC_R_Y: begin
                n_red = r7_val; n_green = r7_t;   n_blue = r7_p;
            end
            SEC_Y_G: begin
                n_red = r7_q;   n_green = r7_val; n_blue = r7_p;
            end
            SEC_G_C: begin
                n_red = r7_p;   n_green = r7_val; n_blue = r7_t;
            end
            SEC_C_B: begin
                n_red = r7_p;   n_green = r7_q;   n_blue = r7_val;
            end
            SEC_B_M: begin
                n_red = r7_t;   n_green = r7_p;   n_blue = r7_val;
            end
            default: begin
                n_red = r7_val; n_green = r7_p;   n_blue = r7_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r1_hue <= n1_hue;
            r1_sat <= s_axis_tdata[20:13];
            r1_val <= s_axis_tdata[28:21];
        end
        if (stage_en[1]) begin
            r2_sec <= n2_sec;
            r2_rem <= n2_diff[9:0];
            r2_sat <= r1_sat;
            r2_val <= r1_val;
        end
        if (stage_en[2]) begin
            r3_sec <= r2_sec;
            r3_a   <= 18'(r2_rem) * 18'(r2_sat);
            r3_b   <= 18'(n3_inv) * 18'(r2_sat);
            r3_pm  <= 16'(r2_val) * 16'(FRAC_ONE - r2_sat);
            r3_val <= r2_val;
        end
        if (stage_en[3]) begin
            r4_sec <= r3_sec;
            r4_nq  <= SECTOR_SCALE - r3_a;
            r4_nt  <= SECTOR_SCALE - r3_b;
            r4_pm  <= r3_pm;
            r4_pa  <= n4_pprod[31:24];
            r4_val <= r3_val;
        end
        if (stage_en[4]) begin
            r5_sec <= r4_sec;
            r5_mq  <= 26'(r4_val) * 26'(r4_nq);
            r5_mt  <= 26'(r4_val) * 26'(r4_nt);
            r5_p   <= n5_p;
            r5_val <= r4_val;
        end
        if (stage_en[5]) begin
            r6_sec <= r5_sec;
            r6_yq  <= n6_yq;
            r6_yt  <= n6_yt;
            r6_qq  <= n6_qprod[39:32];
            r6_qt  <= n6_tprod[39:32];
            r6_p   <= r5_p;
            r6_val <= r5_val;
        end
        if (stage_en[6]) begin
            r7_sec <= r6_sec;
            r7_q   <= n7_q;
            r7_t   <= n7_t;
            r7_p   <= r6_p;
            r7_val <= r6_val;
        end
        if (stage_en[7]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    `HSV_ASSERT(a_sector_range, i_clk, i_rst_n, r_vld[1] |-> (r2_rem < SECTOR_SPAN && r2_sec <= SEC_M_R), "sector split out of range")
    `HSV_ASSERT(a_p_bound, i_clk, i_rst_n, r_vld[4] |-> (r5_p <= r5_val), "p exceeds value")
    `HSV_ASSERT(a_q_residual, i_clk, i_rst_n, r_vld[5] |-> (n7_qres < 20'(SCALE_DIV) * 20'd2 && n7_tres < 20'(SCALE_DIV) * 20'd2), "quotient estimate off by more than one")
    `HSV_ASSERT(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
    `HSV_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// hsv to rgb converter testbench
// streams hue, saturation and value pixels through the converter with random
// gaps on both sides, predicts each rgb result in fixed point and checks every
// output transaction field by field in order
// ----------------------------------------------------------------------------
module tb_top;

    import hsv2rgb_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct {
        logic [12:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        bit          wait_drain;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // hue[12:0], saturation[20:13], brightness[28:21]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]

    t_pixel pending_pixels[$];
    t_rgb   expected_rgb[$];
    int     pixels_in;
    int     error_count;
    bit     in_taken;
    int     send_gap, send_burst;
    int     recv_gap, recv_burst, hold_cycles;
    bit     first_hold_done, second_hold_done;

    hsv_to_rgb_converter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_rgb hsv_to_rgb(logic [12:0] hue, logic [7:0] sat, logic [7:0] val);
        int unsigned h, s, v, span, scale, rem, p_lvl, q_lvl, t_lvl;
        t_sector     sec;
        t_rgb        c;
        h = hue;
        s = sat;
        v = val;
        span = SECTOR_SPAN;
        scale = SECTOR_SCALE;
        if (h >= HUE_FULL) begin
            h = h - HUE_FULL;
        end
        sec = t_sector'(h / span);
        rem = h - (h / span) * span;
        p_lvl = v * (FRAC_ONE - s) / FRAC_ONE;
        q_lvl = v * (scale - rem * s) / scale;
        t_lvl = v * (scale - (span - rem) * s) / scale;
        case (sec)
            SEC_R_Y: begin
                c.red = v[7:0];     c.green = t_lvl[7:0]; c.blue = p_lvl[7:0];
            end
            SEC_Y_G: begin
                c.red = q_lvl[7:0]; c.green = v[7:0];     c.blue = p_lvl[7:0];
            end
            SEC_G_C: begin
                c.red = p_lvl[7:0]; c.green = v[7:0];     c.blue = t_lvl[7:0];
            end
            SEC_C_B: begin
                c.red = p_lvl[7:0]; c.green = q_lvl[7:0]; c.blue = v[7:0];
            end
            SEC_B_M: begin
                c.red = t_lvl[7:0]; c.green = p_lvl[7:0]; c.blue = v[7:0];
            end
            default: begin
                c.red = v[7:0];     c.green = p_lvl[7:0]; c.blue = q_lvl[7:0];
            end
        endcase
        return c;
    endfunction

    // mostly short gaps, some long ones, and now and then a run with none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return 8'd0;
        if (r < 12) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [12:0] pick_hue();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 13'($urandom_range(5760, 8191));
        if (r < 14) return 13'($urandom_range(0, 5) * 960 + $urandom_range(0, 1));
        if (r < 18) return 13'($urandom_range(1, 6) * 960 - 1);
        return 13'($urandom_range(0, 5759));
    endfunction

    task automatic add_pixel(logic [12:0] hue, logic [7:0] sat, logic [7:0] val, bit drain);
        t_pixel px;
        px.hue = hue;
        px.sat = sat;
        px.val = val;
        px.wait_drain = drain;
        pending_pixels.push_back(px);
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_pixel nxt;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0 &&
                         !(pending_pixels[0].wait_drain && expected_rgb.size() != 0)) begin
                nxt = pending_pixels.pop_front();
                s_axis_tdata  <= {3'b000, nxt.val, nxt.sat, nxt.hue};
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap(send_burst);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with two long hold-offs that back the pipe up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (!first_hold_done && pixels_in >= 400) begin
                first_hold_done = 1'b1;
                hold_cycles = 300;
                m_axis_tready <= 1'b0;
            end else if (!second_hold_done && pixels_in >= 900) begin
                second_hold_done = 1'b1;
                hold_cycles = 150;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap = pick_gap(recv_burst);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rgb want, got;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                expected_rgb.push_back(hsv_to_rgb(s_axis_tdata[12:0], s_axis_tdata[20:13],
                                                  s_axis_tdata[28:21]));
                pixels_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_rgb.size() == 0) begin
                    report_mismatch($sformatf("unexpected output transaction 0x%06h", got));
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red: expected %0d, got %0d",
                                                  want.red, got.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green: expected %0d, got %0d",
                                                  want.green, got.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue: expected %0d, got %0d",
                                                  want.blue, got.blue));
                end
            end
        end
    end

    initial begin
        // sector edges, wrapped hues, grey and black
        add_pixel(13'd0,    8'd255, 8'd255, 1'b0);
        add_pixel(13'd959,  8'd255, 8'd255, 1'b0);
        add_pixel(13'd960,  8'd255, 8'd255, 1'b0);
        add_pixel(13'd1919, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd1920, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd2880, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd3840, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd4800, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd5759, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd5760, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd8191, 8'd255, 8'd255, 1'b0);
        add_pixel(13'd6720, 8'd128, 8'd200, 1'b0);
        add_pixel(13'd1000, 8'd0,   8'd200, 1'b1);
        add_pixel(13'd3000, 8'd0,   8'd255, 1'b0);
        add_pixel(13'd2000, 8'd255, 8'd0,   1'b0);
        add_pixel(13'd4000, 8'd128, 8'd0,   1'b0);
        add_pixel(13'd480,  8'd1,   8'd254, 1'b0);
        add_pixel(13'd5000, 8'd254, 8'd1,   1'b0);
        add_pixel(13'd0,    8'd0,   8'd0,   1'b0);
        add_pixel(13'd7000, 8'd170, 8'd85,  1'b0);
        for (int i = 0; i < 1130; i++) begin
            add_pixel(pick_hue(), pick_level(), pick_level(), i == 600);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        do @(negedge i_clk); while (pending_pixels.size() != 0 || s_axis_tvalid);
        while (expected_rgb.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- hsv_to_rgb_converter_top.f -----
+incdir+rtl/core
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_converter_top.sv
tb/tb_top.sv
